// File: rtl/pcdt_pkg.sv
// Package: constants, register indexes and helpers for the pulse capture and duty tick unit.
package pcdt_pkg;

    localparam int unsigned WindowTicks = 2000;
    localparam int unsigned MarkPeriod  = 7000;
    localparam int unsigned TickWrap    = 60000;
    localparam int unsigned BlinkPeriod = 250;

    localparam logic [6:0] FillLimitRst   = 7'd98;
    localparam logic [6:0] FillDefaultRst = 7'd10;
    localparam logic [7:0] PotStepRst     = 8'd100;
    localparam logic [7:0] BlinkTogRst    = 8'd6;
    localparam logic [7:0] PotIndexRst    = 8'd255;

    typedef enum logic [1:0] {
        CFG_FILL_LIMIT   = 2'd0,
        CFG_FILL_DEFAULT = 2'd1,
        CFG_POT_STEP     = 2'd2,
        CFG_BLINK_TOG    = 2'd3
    } t_cfg_idx;

    // ones / 20 as (ones / 4) / 5, the fifth by reciprocal 205 / 1024
    function automatic logic [6:0] div20(input logic [10:0] ones);
        logic [8:0]  quarter;
        logic [17:0] prod;
        quarter = ones[10:2];
        prod    = 18'(quarter) * 18'd205;
        return prod[16:10];
    endfunction

endpackage

// File: rtl/pulse_capture_and_duty_tick_unit_top.sv
// Top level: pulse capture sampling, duty fill, potentiometer step, LEDs and tick counters.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: a 1 ms tick
//   (i_req_type = 0) or a capture event (i_req_type = 1) with its flags and times.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result per
//   request: the new sample (captures only) and the state after the request.
//   A request lands in the input register, then the single-pass state update fills
//   the result register and raises o_out_valid.
//   Throughput is one request per cycle while the receiver does not stall; the update
//   of the counters and LED state in one pass between the two registers sets that figure.
//   While the receiver stalls, the result holds and one further request waits in
//   the input register; o_in_stall rises only when both registers are full.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once; the user
//   must make them only while the block is idle, which the block itself does not enforce.
//   Synchronous reset (i_rst_n low) empties both registers, restores register
//   defaults and clears all counters; the potentiometer index returns to 255.
module pulse_capture_and_duty_tick_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic        i_pin_level,
    input  logic        i_run_enable,
    input  logic        i_fall_flag,
    input  logic        i_rise_flag,
    input  logic [15:0] i_fall_time,
    input  logic [15:0] i_rise_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_sample_valid,
    output logic [15:0] o_sample_time,
    output logic        o_sample_polarity,
    output logic [6:0]  o_duty_fill,
    output logic [7:0]  o_duty_done_count,
    output logic [7:0]  o_pot_index,
    output logic        o_pot_write,
    output logic        o_heartbeat_led,
    output logic        o_activity_led,
    output logic [15:0] o_idle_ticks,
    output logic [15:0] o_run_ticks
);

    logic [6:0]  r_fill_limit;
    logic [6:0]  r_fill_default;
    logic [7:0]  r_pot_step;
    logic [7:0]  r_blink_tog;

    logic        r_in_valid;
    logic        r_req_type;
    logic        r_pin_level;
    logic        r_run_enable;
    logic        r_fall_flag;
    logic        r_rise_flag;
    logic [15:0] r_fall_time;
    logic [15:0] r_rise_time;

    logic [10:0] r_window,   n_window;
    logic [10:0] r_ones,     n_ones;
    logic [6:0]  r_fill,     n_fill;
    logic [7:0]  r_done,     n_done;
    logic [15:0] r_tick,     n_tick;
    logic [12:0] r_ph_mark,  n_ph_mark;
    logic [7:0]  r_ph_blink, n_ph_blink;
    logic [7:0]  r_mark,     n_mark;
    logic [7:0]  r_pot,      n_pot;
    logic        r_armed,    n_armed;
    logic [7:0]  r_blink,    n_blink;
    logic        r_heart,    n_heart;
    logic        r_act,      n_act;
    logic [15:0] r_idle,     n_idle;
    logic [15:0] r_run,      n_run;
    logic        n_valid;
    logic [15:0] n_stime;
    logic        n_pol;
    logic        n_strobe;

    logic        r_out_valid;
    logic        w_out_free;
    logic        w_advance;
    logic [6:0]  w_fill_raw;
    logic [7:0]  w_mark_inc;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign o_out_valid = r_out_valid;
    assign w_fill_raw = pcdt_pkg::div20(r_ones);
    assign w_mark_inc = r_mark + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit   <= pcdt_pkg::FillLimitRst;
            r_fill_default <= pcdt_pkg::FillDefaultRst;
            r_pot_step     <= pcdt_pkg::PotStepRst;
            r_blink_tog    <= pcdt_pkg::BlinkTogRst;
        end else if (i_cfg_we) begin
            unique case (pcdt_pkg::t_cfg_idx'(i_cfg_index))
                pcdt_pkg::CFG_FILL_LIMIT:   r_fill_limit   <= i_cfg_data[6:0];
                pcdt_pkg::CFG_FILL_DEFAULT: r_fill_default <= i_cfg_data[6:0];
                pcdt_pkg::CFG_POT_STEP:     r_pot_step     <= i_cfg_data;
                pcdt_pkg::CFG_BLINK_TOG:    r_blink_tog    <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req_type   <= i_req_type;
            r_pin_level  <= i_pin_level;
            r_run_enable <= i_run_enable;
            r_fall_flag  <= i_fall_flag;
            r_rise_flag  <= i_rise_flag;
            r_fall_time  <= i_fall_time;
            r_rise_time  <= i_rise_time;
        end
    end

    always_comb begin
        n_window   = r_window;
        n_ones     = r_ones;
        n_fill     = r_fill;
        n_done     = r_done;
        n_tick     = r_tick;
        n_ph_mark  = r_ph_mark;
        n_ph_blink = r_ph_blink;
        n_mark     = r_mark;
        n_pot      = r_pot;
        n_armed    = r_armed;
        n_blink    = r_blink;
        n_heart    = r_heart;
        n_act      = r_act;
        n_idle     = r_idle;
        n_run      = r_run;
        n_valid    = 1'b0;
        n_stime    = 16'd0;
        n_pol      = 1'b0;
        n_strobe   = 1'b0;
        if (r_req_type) begin
            n_idle  = 16'd0;
            n_armed = 1'b1;
            priority if (r_fall_flag) begin
                n_valid = 1'b1;
                n_stime = r_fall_time;
                n_pol   = 1'b1;
            end else if (r_rise_flag) begin
                n_valid = 1'b1;
                n_stime = r_rise_time;
            end
        end else begin
            if (r_window == 11'(pcdt_pkg::WindowTicks)) begin
                n_done   = r_done + 8'd1;
                n_ones   = 11'd0;
                n_window = 11'd0;
                n_fill   = (w_fill_raw > r_fill_limit) ? r_fill_default : w_fill_raw;
            end else begin
                n_ones   = r_ones + 11'(r_pin_level);
                n_window = r_window + 11'd1;
            end

            if (r_ph_mark == 13'd0) begin
                if (w_mark_inc == r_pot_step) begin
                    n_mark = 8'd0;
                    if (r_pot != 8'd0) begin
                        n_pot    = r_pot - 8'd1;
                        n_strobe = 1'b1;
                    end
                end else begin
                    n_mark = w_mark_inc;
                end
            end

            // hold the mark and blink phases equal to the tick count modulo their periods
            if (r_tick == 16'(pcdt_pkg::TickWrap - 1)) begin
                n_tick    = 16'd0;
                n_ph_mark = 13'd0;
            end else begin
                n_tick    = r_tick + 16'd1;
                n_ph_mark = (r_ph_mark == 13'(pcdt_pkg::MarkPeriod - 1)) ? 13'd0
                                                                         : r_ph_mark + 13'd1;
            end
            n_ph_blink = (r_ph_blink == 8'(pcdt_pkg::BlinkPeriod - 1)) ? 8'd0
                                                                       : r_ph_blink + 8'd1;

            if (n_ph_blink == 8'd0) begin
                n_heart = !r_heart;
                if (r_armed) begin
                    if (r_blink < r_blink_tog) begin
                        n_blink = r_blink + 8'd1;
                        n_act   = !r_act;
                    end else begin
                        n_armed = 1'b0;
                        n_blink = 8'd0;
                        n_act   = 1'b0;
                    end
                end
            end

            n_idle = r_idle + 16'd1;
            n_run  = r_run + 16'(r_run_enable);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= 11'd0;
            r_ones      <= 11'd0;
            r_fill      <= 7'd0;
            r_done      <= 8'd0;
            r_tick      <= 16'd0;
            r_ph_mark   <= 13'd0;
            r_ph_blink  <= 8'd0;
            r_mark      <= 8'd0;
            r_pot       <= pcdt_pkg::PotIndexRst;
            r_armed     <= 1'b0;
            r_blink     <= 8'd0;
            r_heart     <= 1'b0;
            r_act       <= 1'b0;
            r_idle      <= 16'd0;
            r_run       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_window   <= n_window;
                r_ones     <= n_ones;
                r_fill     <= n_fill;
                r_done     <= n_done;
                r_tick     <= n_tick;
                r_ph_mark  <= n_ph_mark;
                r_ph_blink <= n_ph_blink;
                r_mark     <= n_mark;
                r_pot      <= n_pot;
                r_armed    <= n_armed;
                r_blink    <= n_blink;
                r_heart    <= n_heart;
                r_act      <= n_act;
                r_idle     <= n_idle;
                r_run      <= n_run;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_sample_valid    <= n_valid;
            o_sample_time     <= n_stime;
            o_sample_polarity <= n_pol;
            o_duty_fill       <= n_fill;
            o_duty_done_count <= n_done;
            o_pot_index       <= n_pot;
            o_pot_write       <= n_strobe;
            o_heartbeat_led   <= n_heart;
            o_activity_led    <= n_act;
            o_idle_ticks      <= n_idle;
            o_run_ticks       <= n_run;
        end
    end

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < 16'(pcdt_pkg::TickWrap))
        else $error("tick count left its wrap range");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph_mark < 13'(pcdt_pkg::MarkPeriod) && r_ph_blink < 8'(pcdt_pkg::BlinkPeriod))
        else $error("tick phase counter out of range");

    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window <= 11'(pcdt_pkg::WindowTicks) && r_ones <= r_window)
        else $error("duty window counters inconsistent");

    a_strobe_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pot_write |-> !o_sample_valid)
        else $error("potentiometer strobe on a capture result");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(r_pot) && $stable(r_idle))
        else $error("state advanced while result stalled");

endmodule
